>>> hdl/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// ante implies cons in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication failed");

// sig keeps its value in the cycle after ante
`define ASSERT_HOLDS(label, clk, rst, ante, sig) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> $stable(sig)) \
    else $error("value changed while held");

`endif

>>> hdl/hgep_pkg.sv
// ----------------------------------------------------------------------------
// hgep_pkg
// Shared codes, item and result types of the hypergraph edge peeler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hgep_pkg;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FEW       = 2'd1;
  localparam logic [1:0] ST_IGNORED   = 2'd2;
  localparam logic [1:0] ST_BAD_INDEX = 2'd3;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;
  localparam logic [CFG_IDX_W-1:0] REG_RANK = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_KEYS = 1'b1;

  localparam logic [1:0]  RANK_RESET = 2'd3;
  localparam logic [10:0] KEYS_RESET = 11'd1;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_LOAD = 2'd1,
    PH_DONE = 2'd2,
    PH_FAIL = 2'd3
  } phase_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] hash_word0;
    logic [31:0] hash_word1;
    logic [31:0] hash_word2;
    logic        last_key;
    logic [9:0]  read_index;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [10:0] unpeeled;
    logic [9:0]  order_edge;
    logic        peel_done;
  } result_t;

endpackage

`default_nettype wire

>>> hdl/hgep_queue.sv
// ----------------------------------------------------------------------------
// hgep_queue
// Two-entry queue that decouples the ports from the build engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hgep_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  logic [WIDTH-1:0] mem [2];
  logic             wp;
  logic             rp;
  logic [1:0]       cnt;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt == 2'd2);
  assign empty   = (cnt == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (do_push) wp <= ~wp;
      if (do_pop) rp <= ~rp;
      if (do_push && !do_pop) cnt <= cnt + 2'd1;
      else if (do_pop && !do_push) cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wp] <= din;
  end

endmodule

`default_nettype wire

>>> hdl/hgep_divider.sv
// ----------------------------------------------------------------------------
// hgep_divider
// Restoring divider, one quotient bit per cycle, 32-bit dividend.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hgep_divider #(
  parameter int DW = 12
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [31:0]   dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [31:0]   quotient,
  output logic [DW-1:0] remainder
);

  logic          busy;
  logic [4:0]    cnt;
  logic [31:0]   q;
  logic [DW-1:0] rem;
  logic [DW-1:0] d;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  assign trial     = {rem, q[31]};
  assign diff      = trial - {1'b0, d};
  assign ge        = (trial >= {1'b0, d});
  assign quotient  = q;
  assign remainder = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'd0;
        q    <= dividend;
        rem  <= '0;
        d    <= divisor;
      end else if (busy) begin
        rem <= ge ? diff[DW-1:0] : trial[DW-1:0];
        q   <= {q[30:0], ge};
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/hgep_engine.sv
// ----------------------------------------------------------------------------
// hgep_engine
// Build and peel sequencer with edge, incidence and order stores.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hgep_engine #(
  parameter int MAX_KEYS  = 1024,
  parameter int MAX_VERTS = 4096,
  parameter int MIN_VERTS = 24
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  input  logic [hgep_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hgep_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  input  hgep_pkg::item_t                  in_item,
  output logic                             in_pop,
  input  logic                             out_full,
  output logic                             out_push,
  output hgep_pkg::result_t                out_res
);

  import hgep_pkg::*;

  localparam int VW   = $clog2(MAX_VERTS);
  localparam int KW   = $clog2(MAX_KEYS);
  localparam int CAP2 = MAX_VERTS / 2;
  localparam int CAP3 = MAX_VERTS / 3;

  typedef struct packed {
    logic [VW-1:0] o0;
    logic [VW-1:0] o1;
    logic [KW:0]   deg;
    logic [KW-1:0] eno;
  } inc_rec_t;

  typedef enum logic [4:0] {
    S_IDLE, S_CLR_DIV, S_CLR, S_KDIV_GO, S_KDIV, S_EW, S_TRD, S_TWR, S_KFIN,
    S_P1, S_P1_INC, S_PV_RD, S_PV_CHK, S_P2_CHK, S_P2_EDG, S_P2_EDGW,
    S_P2_R, S_P2_RINC, S_RD_ORD, S_RD_OUT, S_EMIT
  } state_t;

  state_t        state;
  phase_t        phase;
  logic [1:0]    cfg_rank;
  logic [10:0]   cfg_keys;
  logic          rank3;
  logic [KW:0]   keys_cur;
  logic [KW:0]   loaded;
  logic [KW:0]   unpeeled;
  logic [KW:0]   endc;
  logic [KW:0]   icnt;
  logic [VW-1:0] part;
  logic [VW:0]   vtotal;
  logic [VW:0]   vcnt;
  logic [VW-1:0] pv;
  item_t         item;
  logic [1:0]    rsel;
  logic [VW-1:0] vs [3];
  logic [VW-1:0] tgt [3];
  logic [VW-1:0] ta [3];
  logic [VW-1:0] tb [3];
  logic [1:0]    tcnt;
  logic [1:0]    tidx;
  logic [KW-1:0] te;
  logic          tdec;
  logic          tpeel;
  logic          ret_p2;
  logic [1:0]    st_r;
  logic [9:0]    oe_r;
  logic          done_r;

  inc_rec_t      inc_mem [MAX_VERTS];
  logic [3*VW-1:0] edge_mem [MAX_KEYS];
  logic [KW-1:0] ord_mem [MAX_KEYS];
  inc_rec_t      inc_q;
  logic [3*VW-1:0] edge_q;
  logic [KW-1:0] ord_q;

  logic          inc_we;
  logic [VW-1:0] inc_wa;
  inc_rec_t      inc_wd;
  logic [VW-1:0] inc_ra;
  logic          ord_we;
  logic [KW-1:0] ord_wa;
  logic [KW-1:0] ord_ra;
  logic          edge_we;

  logic          div_start;
  logic [31:0]   div_dividend;
  logic [VW-1:0] div_divisor;
  logic          div_done;
  logic [31:0]   div_quot;
  logic [VW-1:0] div_rem;

  logic [KW:0]   n_clamp;
  logic [31:0]   n32;
  logic [31:0]   xv;
  logic [31:0]   clr_dividend;
  logic [31:0]   q_cap;
  logic [VW-1:0] part_new;
  logic [VW:0]   vtotal_new;
  logic [31:0]   hw_sel;
  logic [VW-1:0] off;
  logic [VW-1:0] vs_new;
  logic [VW-1:0] a_v;
  logic [VW-1:0] b_v;
  logic [VW-1:0] add0;
  logic [VW-1:0] add1;
  inc_rec_t      rec_new;
  logic          deg_one;

  hgep_divider #(.DW(VW)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  // vertex count from the configured key count, and part size from the divider quotient
  always_comb begin
    if (cfg_keys == 11'd0) n_clamp = (KW+1)'(1);
    else if (32'(cfg_keys) > 32'(MAX_KEYS)) n_clamp = (KW+1)'(MAX_KEYS);
    else n_clamp = (KW+1)'(cfg_keys);
    n32 = 32'(n_clamp);
    if (cfg_rank == 2'd2) xv = (n32 << 1) + ((n32 + 32'd7) >> 3);
    else xv = n32 + ((n32 + 32'd3) >> 2);
    if (xv < 32'(MIN_VERTS)) xv = 32'(MIN_VERTS);
    clr_dividend = xv + ((cfg_rank == 2'd2) ? 32'd1 : 32'd2);
    if (rank3) q_cap = (div_quot > 32'(CAP3)) ? 32'(CAP3) : div_quot;
    else q_cap = (div_quot > 32'(CAP2)) ? 32'(CAP2) : div_quot;
    part_new = VW'(q_cap);
    if (rank3) vtotal_new = {1'b0, part_new} + {part_new, 1'b0};
    else vtotal_new = {part_new, 1'b0};
  end

  always_comb begin
    case (rsel)
      2'd0:    hw_sel = item.hash_word0;
      2'd1:    hw_sel = item.hash_word1;
      default: hw_sel = item.hash_word2;
    endcase
    case (rsel)
      2'd0:    off = '0;
      2'd1:    off = part;
      default: off = {part[VW-2:0], 1'b0};
    endcase
    vs_new = div_rem + off;
  end

  assign div_start    = (in_pop && in_item.operation == OP_CLEAR) || (state == S_KDIV_GO);
  assign div_dividend = (state == S_IDLE) ? clr_dividend : hw_sel;
  assign div_divisor  = (state == S_IDLE) ? ((cfg_rank == 2'd2) ? VW'(2) : VW'(3)) : part;

  // incidence record update for one touch
  always_comb begin
    a_v  = ta[tidx];
    b_v  = tb[tidx];
    add0 = rank3 ? ((a_v < b_v) ? a_v : b_v) : a_v;
    add1 = rank3 ? ((a_v < b_v) ? b_v : a_v) : '0;
    rec_new.o0  = inc_q.o0 ^ add0;
    rec_new.o1  = inc_q.o1 ^ add1;
    rec_new.deg = tdec ? (inc_q.deg - (KW+1)'(1)) : (inc_q.deg + (KW+1)'(1));
    rec_new.eno = inc_q.eno ^ te;
  end

  assign deg_one = (inc_q.deg == (KW+1)'(1));

  always_comb begin
    inc_we = 1'b0;
    inc_wa = tgt[tidx];
    inc_wd = rec_new;
    unique case (state)
      S_CLR: begin
        inc_we = 1'b1;
        inc_wa = vcnt[VW-1:0];
        inc_wd = '0;
      end
      S_TWR: begin
        inc_we = 1'b1;
      end
      S_PV_CHK: begin
        inc_we     = deg_one;
        inc_wa     = pv;
        inc_wd     = inc_q;
        inc_wd.deg = '0;
      end
      default: ;
    endcase
  end

  assign inc_ra  = (state == S_PV_RD) ? pv : tgt[tidx];
  assign ord_we  = (state == S_PV_CHK) && deg_one;
  assign ord_wa  = KW'(endc - (KW+1)'(1));
  assign ord_ra  = (state == S_P2_CHK) ? KW'(icnt - (KW+1)'(1)) : KW'(item.read_index);
  assign edge_we = (state == S_EW);

  always_ff @(posedge clk) begin
    if (inc_we) inc_mem[inc_wa] <= inc_wd;
    inc_q <= inc_mem[inc_ra];
  end

  always_ff @(posedge clk) begin
    if (ord_we) ord_mem[ord_wa] <= inc_q.eno;
    ord_q <= ord_mem[ord_ra];
  end

  always_ff @(posedge clk) begin
    if (edge_we) edge_mem[loaded[KW-1:0]] <= {vs[2], vs[1], vs[0]};
    edge_q <= edge_mem[ord_q];
  end

  assign in_pop           = (state == S_IDLE) && in_valid && !out_full;
  assign out_push         = (state == S_EMIT);
  assign out_res.status     = st_r;
  assign out_res.unpeeled   = 11'(unpeeled);
  assign out_res.order_edge = oe_r;
  assign out_res.peel_done  = done_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      phase    <= PH_IDLE;
      cfg_rank <= RANK_RESET;
      cfg_keys <= KEYS_RESET;
      rank3    <= 1'b1;
      keys_cur <= (KW+1)'(1);
      loaded   <= '0;
      unpeeled <= '0;
      vtotal   <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_RANK: cfg_rank <= cfg_data[1:0];
          default:  cfg_keys <= cfg_data;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (in_pop) begin
            item   <= in_item;
            st_r   <= ST_OK;
            oe_r   <= '0;
            done_r <= 1'b0;
            unique case (in_item.operation)
              OP_CLEAR: begin
                rank3    <= (cfg_rank != 2'd2);
                keys_cur <= n_clamp;
                state    <= S_CLR_DIV;
              end
              OP_ADD: begin
                if (phase != PH_LOAD || loaded >= keys_cur) begin
                  st_r  <= ST_IGNORED;
                  state <= S_EMIT;
                end else begin
                  rsel  <= 2'd0;
                  vs[2] <= '0;
                  state <= S_KDIV_GO;
                end
              end
              OP_READ: state <= S_RD_ORD;
              default: begin
                st_r  <= ST_IGNORED;
                state <= S_EMIT;
              end
            endcase
          end
        end
        S_CLR_DIV: begin
          if (div_done) begin
            part   <= part_new;
            vtotal <= vtotal_new;
            vcnt   <= '0;
            state  <= S_CLR;
          end
        end
        S_CLR: begin
          if (vcnt + (VW+1)'(1) == vtotal) begin
            loaded   <= '0;
            unpeeled <= '0;
            phase    <= PH_LOAD;
            state    <= S_EMIT;
          end else begin
            vcnt <= vcnt + (VW+1)'(1);
          end
        end
        S_KDIV_GO: state <= S_KDIV;
        S_KDIV: begin
          if (div_done) begin
            vs[rsel] <= vs_new;
            if (rsel == (rank3 ? 2'd2 : 2'd1)) begin
              state <= S_EW;
            end else begin
              rsel  <= rsel + 2'd1;
              state <= S_KDIV_GO;
            end
          end
        end
        S_EW: begin
          tgt[0] <= vs[0]; ta[0] <= vs[1]; tb[0] <= vs[2];
          tgt[1] <= vs[1]; ta[1] <= vs[0]; tb[1] <= vs[2];
          tgt[2] <= vs[2]; ta[2] <= vs[0]; tb[2] <= vs[1];
          tcnt  <= rank3 ? 2'd3 : 2'd2;
          tidx  <= 2'd0;
          te    <= loaded[KW-1:0];
          tdec  <= 1'b0;
          tpeel <= 1'b0;
          state <= S_TRD;
        end
        S_TRD: state <= S_TWR;
        S_TWR: begin
          if (tidx + 2'd1 == tcnt) begin
            if (!tpeel) state <= S_KFIN;
            else state <= ret_p2 ? S_P2_RINC : S_P1_INC;
          end else begin
            tidx  <= tidx + 2'd1;
            state <= S_TRD;
          end
        end
        S_KFIN: begin
          loaded <= loaded + (KW+1)'(1);
          if (loaded + (KW+1)'(1) == keys_cur) begin
            endc  <= keys_cur;
            vcnt  <= '0;
            state <= S_P1;
          end else if (item.last_key) begin
            unpeeled <= keys_cur;
            phase    <= PH_FAIL;
            st_r     <= ST_FEW;
            state    <= S_EMIT;
          end else begin
            state <= S_EMIT;
          end
        end
        S_P1: begin
          if (vcnt < vtotal) begin
            pv     <= vcnt[VW-1:0];
            ret_p2 <= 1'b0;
            state  <= S_PV_RD;
          end else begin
            icnt  <= keys_cur;
            state <= S_P2_CHK;
          end
        end
        S_P1_INC: begin
          vcnt  <= vcnt + (VW+1)'(1);
          state <= S_P1;
        end
        S_PV_RD: begin
          if (endc == '0) state <= ret_p2 ? S_P2_RINC : S_P1_INC;
          else state <= S_PV_CHK;
        end
        S_PV_CHK: begin
          if (!deg_one) begin
            state <= ret_p2 ? S_P2_RINC : S_P1_INC;
          end else begin
            tgt[0] <= inc_q.o0; ta[0] <= pv; tb[0] <= inc_q.o1;
            tgt[1] <= inc_q.o1; ta[1] <= pv; tb[1] <= inc_q.o0;
            tcnt  <= rank3 ? 2'd2 : 2'd1;
            tidx  <= 2'd0;
            te    <= inc_q.eno;
            tdec  <= 1'b1;
            tpeel <= 1'b1;
            endc  <= endc - (KW+1)'(1);
            state <= S_TRD;
          end
        end
        S_P2_CHK: begin
          if (icnt != '0 && icnt > endc) begin
            state <= S_P2_EDG;
          end else begin
            unpeeled <= endc;
            phase    <= PH_DONE;
            done_r   <= 1'b1;
            state    <= S_EMIT;
          end
        end
        S_P2_EDG: state <= S_P2_EDGW;
        S_P2_EDGW: begin
          vs[0] <= edge_q[VW-1:0];
          vs[1] <= edge_q[2*VW-1:VW];
          vs[2] <= edge_q[3*VW-1:2*VW];
          rsel  <= 2'd0;
          state <= S_P2_R;
        end
        S_P2_R: begin
          if (rsel <= (rank3 ? 2'd2 : 2'd1)) begin
            pv     <= vs[rsel];
            ret_p2 <= 1'b1;
            state  <= S_PV_RD;
          end else begin
            icnt  <= icnt - (KW+1)'(1);
            state <= S_P2_CHK;
          end
        end
        S_P2_RINC: begin
          rsel  <= rsel + 2'd1;
          state <= S_P2_R;
        end
        S_RD_ORD: state <= S_RD_OUT;
        S_RD_OUT: begin
          if (phase == PH_DONE && 32'(item.read_index) >= 32'(unpeeled)
              && 32'(item.read_index) < 32'(keys_cur)) begin
            oe_r <= 10'(ord_q);
          end else begin
            st_r <= ST_BAD_INDEX;
          end
          state <= S_EMIT;
        end
        S_EMIT: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hdl/hypergraph_edge_peeler.sv
// ----------------------------------------------------------------------------
// hypergraph_edge_peeler
// Builds a random 2- or 3-uniform hypergraph from hashed keys and peels it.
// ----------------------------------------------------------------------------
// clear: divider, then one incidence entry per cycle
// add key: one bit-serial divider run per edge vertex, then one incidence read and write per touch
// final key adds the peel: a scan over every vertex, then a pass back over the order list
// read: order store lookup; the engine takes one item at a time, and each beat passes through a queue
// synchronous reset: phase idle, rank 3, key count 1; stores are not cleared
`timescale 1ns / 1ps
`default_nettype none

module hypergraph_edge_peeler #(
  parameter int MAX_KEYS  = 1024,
  parameter int MAX_VERTS = 4096,
  parameter int MIN_VERTS = 24
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic [1:0]                      operation,
  input  logic [31:0]                     hash_word0,
  input  logic [31:0]                     hash_word1,
  input  logic [31:0]                     hash_word2,
  input  logic                            last_key,
  input  logic [9:0]                      read_index,
  output logic                            empty,
  input  logic                            pop,
  output logic [1:0]                      status,
  output logic [10:0]                     unpeeled,
  output logic [9:0]                      order_edge,
  output logic                            peel_done,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [hgep_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hgep_pkg::CFG_DATA_W-1:0] cfg_data
);

  import hgep_pkg::*;

  item_t   in_beat;
  item_t   head;
  result_t res_in;
  result_t res_out;
  logic    in_empty;
  logic    in_pop;
  logic    out_full;
  logic    out_push;

  assign cfg_ready = 1'b1;

  assign in_beat.operation  = operation;
  assign in_beat.hash_word0 = hash_word0;
  assign in_beat.hash_word1 = hash_word1;
  assign in_beat.hash_word2 = hash_word2;
  assign in_beat.last_key   = last_key;
  assign in_beat.read_index = read_index;

  hgep_queue #(.WIDTH($bits(item_t))) u_in_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (in_beat),
    .full  (full),
    .pop   (in_pop),
    .dout  (head),
    .empty (in_empty)
  );

  hgep_engine #(
    .MAX_KEYS  (MAX_KEYS),
    .MAX_VERTS (MAX_VERTS),
    .MIN_VERTS (MIN_VERTS)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (!in_empty),
    .in_item   (head),
    .in_pop    (in_pop),
    .out_full  (out_full),
    .out_push  (out_push),
    .out_res   (res_in)
  );

  hgep_queue #(.WIDTH($bits(result_t))) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .din   (res_in),
    .full  (out_full),
    .pop   (pop),
    .dout  (res_out),
    .empty (empty)
  );

  assign status     = res_out.status;
  assign unpeeled   = res_out.unpeeled;
  assign order_edge = res_out.order_edge;
  assign peel_done  = res_out.peel_done;

endmodule

`default_nettype wire

>>> hdl/hgep_checker.sv
// ----------------------------------------------------------------------------
// hgep_checker
// Port-level checks on the result side of the edge peeler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module hgep_checker (
  input logic        clk,
  input logic        rst,
  input logic        empty,
  input logic        pop,
  input logic [1:0]  status,
  input logic [10:0] unpeeled,
  input logic [9:0]  order_edge,
  input logic        peel_done
);

  import hgep_pkg::*;

  `ASSERT_HOLDS(a_res_hold, clk, rst, !empty && !pop, {status, unpeeled, order_edge, peel_done})
  `ASSERT_IMPLIES(a_done_ok, clk, rst, !empty && peel_done, status == ST_OK && order_edge == 10'd0)
  `ASSERT_IMPLIES(a_few_count, clk, rst, !empty && status == ST_FEW, unpeeled != 11'd0)
  `ASSERT_IMPLIES(a_edge_ok, clk, rst, !empty && order_edge != 10'd0, status == ST_OK)

endmodule

bind hypergraph_edge_peeler hgep_checker u_checker (.*);

`default_nettype wire

>>> verif/hypergraph_edge_peeler_tb.sv
// ----------------------------------------------------------------------------
// hypergraph_edge_peeler_tb
// Self-checking bench for the edge peeler. A queue of pending items feeds a
// clocked driver. Each accepted item goes through a software copy of the
// build and peel state to produce its expected result. A clocked monitor
// compares every result beat, field by field, with the oldest expectation.
// Builds cover both ranks, clamped key counts, early last keys, ignored keys,
// order reads inside and outside the peeled region, and two 1024-key builds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hypergraph_edge_peeler_tb;
  import hgep_pkg::*;

  localparam int MAX_KEYS  = 1024;
  localparam int MAX_VERTS = 4096;
  localparam int MIN_VERTS = 24;
  localparam int WATCHDOG  = 400000;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int IDLE_NONE = 0;
  localparam int IDLE_SEND = 1;
  localparam int IDLE_RECV = 2;
  localparam int IDLE_BOTH = 3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic [1:0] operation = '0;
  logic [31:0] hash_word0 = '0;
  logic [31:0] hash_word1 = '0;
  logic [31:0] hash_word2 = '0;
  logic last_key = 1'b0;
  logic [9:0] read_index = '0;
  logic empty;
  logic pop = 1'b0;
  logic [1:0] status;
  logic [10:0] unpeeled;
  logic [9:0] order_edge;
  logic peel_done;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  hypergraph_edge_peeler DUT (.*);

  // peeler state copy
  int unsigned edge_verts [MAX_KEYS][3];
  int unsigned inc_other0 [MAX_VERTS];
  int unsigned inc_other1 [MAX_VERTS];
  int unsigned inc_degree [MAX_VERTS];
  int unsigned inc_edge   [MAX_VERTS];
  int unsigned order_list [MAX_KEYS];
  int unsigned keys_loaded, unpeeled_count, vertex_total;
  phase_t      build_phase;
  int unsigned reg_rank, reg_keys, build_rank, build_keys;

  item_t   pending_items[$];
  result_t expected_results[$];
  int      idle_mode = IDLE_NONE;
  int      errors = 0;
  int      items_sent = 0;
  int      results_seen = 0;
  int      builds_done = 0;
  int      quiet_cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void touch_vertex(int unsigned v, int unsigned e, int unsigned a,
                                       int unsigned b, int unsigned delta);
    if (v >= MAX_VERTS) return;
    if (build_rank == 2) begin
      inc_other0[v] ^= a;
    end else if (a < b) begin
      inc_other0[v] ^= a;
      inc_other1[v] ^= b;
    end else begin
      inc_other1[v] ^= a;
      inc_other0[v] ^= b;
    end
    inc_degree[v] += delta;
    inc_edge[v] ^= e;
  endfunction

  function automatic int unsigned peel_one(int unsigned v, int unsigned top);
    int unsigned e, v1, v2;
    if (v >= MAX_VERTS) return top;
    if (inc_degree[v] != 1 || top == 0) return top;
    e = inc_edge[v];
    v1 = inc_other0[v];
    v2 = inc_other1[v];
    inc_degree[v] = 0;
    if (build_rank == 2) begin
      touch_vertex(v1, e, v, 0, 32'hFFFF_FFFF);
    end else begin
      touch_vertex(v1, e, v, v2, 32'hFFFF_FFFF);
      touch_vertex(v2, e, v, v1, 32'hFFFF_FFFF);
    end
    top--;
    order_list[top] = e & 10'h3FF;
    return top;
  endfunction

  function automatic int unsigned peel_graph();
    int unsigned top, e;
    top = build_keys;
    for (int unsigned v = 0; v < vertex_total; v++) top = peel_one(v, top);
    for (int unsigned i = build_keys; i > 0 && i > top; i--) begin
      e = order_list[i-1];
      if (e < MAX_KEYS) begin
        for (int unsigned r = 0; r < build_rank; r++) top = peel_one(edge_verts[e][r], top);
      end
    end
    return top;
  endfunction

  function automatic void open_build();
    int unsigned n, nv;
    build_rank = (reg_rank == 2) ? 2 : 3;
    n = reg_keys;
    if (n == 0) n = 1;
    if (n > MAX_KEYS) n = MAX_KEYS;
    build_keys = n;
    if (build_rank == 2) nv = 2 * n + (n + 7) / 8;
    else nv = n + (n + 3) / 4;
    if (nv < MIN_VERTS) nv = MIN_VERTS;
    nv = (nv + build_rank - 1) / build_rank * build_rank;
    if (nv > MAX_VERTS / build_rank * build_rank) nv = MAX_VERTS / build_rank * build_rank;
    vertex_total = nv;
    for (int v = 0; v < MAX_VERTS; v++) begin
      inc_other0[v] = 0;
      inc_other1[v] = 0;
      inc_degree[v] = 0;
      inc_edge[v] = 0;
    end
    keys_loaded = 0;
    unpeeled_count = 0;
    build_phase = PH_LOAD;
  endfunction

  function automatic result_t predict_peeler(item_t it);
    result_t res;
    int unsigned part, e;
    int unsigned w [3];
    res = '0;
    case (it.operation)
      OP_CLEAR: open_build();
      OP_ADD: begin
        if (build_phase != PH_LOAD || keys_loaded >= build_keys) begin
          res.status = ST_IGNORED;
        end else begin
          part = vertex_total / build_rank;
          e = keys_loaded;
          w[0] = it.hash_word0;
          w[1] = it.hash_word1;
          w[2] = it.hash_word2;
          edge_verts[e][2] = 0;
          for (int unsigned r = 0; r < build_rank; r++) edge_verts[e][r] = w[r] % part + r * part;
          if (build_rank == 2) begin
            touch_vertex(edge_verts[e][0], e, edge_verts[e][1], 0, 1);
            touch_vertex(edge_verts[e][1], e, edge_verts[e][0], 0, 1);
          end else begin
            touch_vertex(edge_verts[e][0], e, edge_verts[e][1], edge_verts[e][2], 1);
            touch_vertex(edge_verts[e][1], e, edge_verts[e][0], edge_verts[e][2], 1);
            touch_vertex(edge_verts[e][2], e, edge_verts[e][0], edge_verts[e][1], 1);
          end
          keys_loaded++;
          if (keys_loaded == build_keys) begin
            unpeeled_count = peel_graph();
            build_phase = PH_DONE;
            res.peel_done = 1'b1;
          end else if (it.last_key) begin
            unpeeled_count = build_keys;
            build_phase = PH_FAIL;
            res.status = ST_FEW;
          end
        end
      end
      OP_READ: begin
        if (build_phase == PH_DONE && it.read_index >= unpeeled_count &&
            it.read_index < build_keys) begin
          res.order_edge = order_list[it.read_index][9:0];
        end else begin
          res.status = ST_BAD_INDEX;
        end
      end
      default: res.status = ST_IGNORED;
    endcase
    res.unpeeled = unpeeled_count[10:0];
    return res;
  endfunction

  function automatic bit roll_idle(bit sender);
    case (idle_mode)
      IDLE_SEND: return sender && ($urandom_range(99) < 59);
      IDLE_RECV: return !sender && ($urandom_range(99) < 59);
      IDLE_BOTH: return $urandom_range(99) < 11;
      default:   return 1'b0;
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        expected_results.push_back(predict_peeler(
          '{operation, hash_word0, hash_word1, hash_word2, last_key, read_index}));
        items_sent++;
      end
      if (!(push && full)) begin
        if (pending_items.size() > 0 && !roll_idle(1'b1)) begin
          item_t it;
          it = pending_items.pop_front();
          push <= 1'b1;
          operation <= it.operation;
          hash_word0 <= it.hash_word0;
          hash_word1 <= it.hash_word1;
          hash_word2 <= it.hash_word2;
          last_key <= it.last_key;
          read_index <= it.read_index;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("unexpected result beat: status %0d unpeeled %0d", status, unpeeled);
          errors++;
        end else begin
          result_t exp_res;
          exp_res = expected_results.pop_front();
          if (status !== exp_res.status) begin
            $error("status: expected %0d, got %0d", exp_res.status, status);
            errors++;
          end
          if (unpeeled !== exp_res.unpeeled) begin
            $error("unpeeled: expected %0d, got %0d", exp_res.unpeeled, unpeeled);
            errors++;
          end
          if (order_edge !== exp_res.order_edge) begin
            $error("order_edge: expected %0d, got %0d", exp_res.order_edge, order_edge);
            errors++;
          end
          if (peel_done !== exp_res.peel_done) begin
            $error("peel_done: expected %0d, got %0d", exp_res.peel_done, peel_done);
            errors++;
          end
        end
      end
      pop <= !roll_idle(1'b0);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG) begin
      $display("timeout: no beat for %0d cycles", WATCHDOG);
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_items.size() > 0 || push || expected_results.size() > 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CFG_DATA_W-1:0];
    do @(posedge clk);
    while (!cfg_ready);
    if (idx == REG_RANK) reg_rank = value & 2'h3;
    else reg_keys = value & 11'h7FF;
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_item(logic [1:0] op, logic [31:0] w0, logic [31:0] w1,
                            logic [31:0] w2, logic lk, logic [9:0] idx);
    item_t it;
    it = '{op, w0, w1, w2, lk, idx};
    pending_items.push_back(it);
  endtask

  task automatic queue_key(logic lk);
    queue_item(OP_ADD, $urandom, $urandom, $urandom, lk, $urandom);
  endtask

  // one build: clear, keys (maybe cut short), reads and noise
  task automatic run_build(int unsigned rank_val, int unsigned keys_val);
    int unsigned n, cut;
    wait_drained();
    write_reg(REG_RANK, rank_val);
    write_reg(REG_KEYS, keys_val);
    n = (keys_val == 0) ? 1 : ((keys_val > MAX_KEYS) ? MAX_KEYS : keys_val);
    cut = ($urandom_range(99) < 15 && n > 1) ? $urandom_range(1, n - 1) : n;
    queue_item(OP_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom);
    for (int unsigned k = 1; k <= cut; k++) begin
      if ($urandom_range(99) < 3) queue_item(OP_UNUSED, $urandom, $urandom, $urandom, 0, $urandom);
      queue_key((k == cut) ? (cut < n || $urandom_range(1)) : ($urandom_range(99) < 1 && k == n));
    end
    if ($urandom_range(1)) queue_key($urandom_range(1));
    for (int i = 0; i < 6; i++) begin
      queue_item(OP_READ, $urandom, $urandom, $urandom, $urandom,
                 ($urandom_range(3) == 0) ? 10'($urandom) : 10'($urandom_range(n - 1)));
    end
    builds_done++;
  endtask

  initial begin
    for (int i = 0; i < MAX_KEYS; i++) order_list[i] = 0;
    keys_loaded = 0;
    unpeeled_count = 0;
    vertex_total = 0;
    build_phase = PH_IDLE;
    reg_rank = RANK_RESET;
    reg_keys = KEYS_RESET;
    build_rank = 3;
    build_keys = 1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: no build open, reset config, extreme words
    queue_item(OP_ADD, '1, '1, '1, 1'b1, '1);
    queue_item(OP_READ, '0, '0, '0, 1'b0, '0);
    queue_item(OP_UNUSED, '1, '1, '1, 1'b1, '1);
    queue_item(OP_CLEAR, '0, '0, '0, 1'b0, '0);
    queue_item(OP_ADD, '1, '1, '1, 1'b1, '0);
    queue_item(OP_ADD, '0, '0, '0, 1'b0, '0);
    queue_item(OP_READ, '0, '0, '0, 1'b0, 10'd0);
    queue_item(OP_READ, '0, '0, '0, 1'b0, 10'd1);
    queue_item(OP_READ, '0, '0, '0, 1'b0, 10'h3FF);
    wait_drained();
    // rank 2, early last key, then keys after the failure
    write_reg(REG_RANK, 2);
    write_reg(REG_KEYS, 3);
    queue_item(OP_CLEAR, '0, '0, '0, 1'b0, '0);
    queue_item(OP_ADD, '0, '0, '0, 1'b0, '0);
    queue_item(OP_ADD, '1, '0, '1, 1'b1, '0);
    queue_item(OP_ADD, '1, '1, '1, 1'b0, '0);
    queue_item(OP_READ, '0, '0, '0, 1'b0, 10'd2);
    // clear after the failure, a full three-key build, then reads
    queue_item(OP_CLEAR, '0, '0, '0, 1'b0, '0);
    queue_item(OP_ADD, 32'h7878_7877, 32'hCCCC_CCCA, '1, 1'b0, '0);
    queue_item(OP_ADD, '1, 32'h8000_0000, '0, 1'b0, '0);
    queue_item(OP_ADD, 32'h5555_5555, 32'hAAAA_AAAA, '0, 1'b1, '0);
    queue_item(OP_READ, '0, '0, '0, 1'b0, 10'd0);
    queue_item(OP_READ, '0, '0, '0, 1'b0, 10'd2);
    run_build(0, 0);
    run_build(1, 2047);

    // random builds over the idling modes
    for (int m = IDLE_NONE; m <= IDLE_BOTH; m++) begin
      wait_drained();
      idle_mode = m;
      for (int b = 0; b < 6; b++) begin
        run_build($urandom_range(3), ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 24));
      end
    end
    wait_drained();
    idle_mode = IDLE_NONE;
    run_build(2, 1024);

    wait_drained();
    repeat (100) @(posedge clk);
    $display("covered %0d builds over ranks 2 and 3, %0d items sent, %0d results checked",
             builds_done, items_sent, results_seen);
    $display("idling modes: none, sender gaps, receiver stalls, both");
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
